// ===== rtl/core/trf_pkg.sv =====
`timescale 1ns / 1ps
package trf_pkg;

  localparam int CAPACITY  = 1024;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int PTR_W     = $clog2(2 * CAPACITY);
  localparam int FILL_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_KIND = CFG_IDX_W'(1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] event_type;
    logic [63:0] time_stamp;
    logic [63:0] span;
    logic [63:0] extra_word;
  } item_t;

  typedef struct packed {
    logic              out_valid;
    logic              accepted;
    logic              marker_inserted;
    logic [15:0]       out_type;
    logic [63:0]       out_time_stamp;
    logic [63:0]       out_span;
    logic [63:0]       out_extra;
    logic [FILL_W-1:0] fill_level;
    logic [63:0]       dropped_total;
    logic [63:0]       pending_drops;
  } result_t;

  typedef struct packed {
    logic [15:0] ev_type;
    logic [63:0] stamp;
    logic [63:0] span;
    logic [63:0] extra;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t ev;
  } cmd_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] loss_kind_code;
  } cfg_t;

endpackage

// ===== rtl/core/trf_front.sv =====
`timescale 1ns / 1ps
module trf_front
  import trf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_take
);

  cmd_t       q [2];
  logic [1:0] cnt;
  logic       wr_idx;
  logic       rd_idx;
  logic       push_ok;
  logic       take_ok;
  cmd_t       decoded;

  always_comb begin
    decoded.op       = op_t'(item.kind);
    decoded.ev       = '0;
    if (decoded.op == OP_APPEND) begin
      decoded.ev.ev_type = item.event_type;
      decoded.ev.stamp   = item.time_stamp;
      decoded.ev.span    = item.span;
      decoded.ev.extra   = item.extra_word;
    end
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_idx];
  assign push_ok   = push && !full;
  assign take_ok   = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_idx] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_idx <= !wr_idx;
      end
      if (take_ok) begin
        rd_idx <= !rd_idx;
      end
      if (push_ok && !take_ok) begin
        cnt <= cnt + 2'd1;
      end else if (take_ok && !push_ok) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/trf_back.sv =====
`timescale 1ns / 1ps
module trf_back
  import trf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam logic [PTR_W:0] PTR_MOD = (PTR_W + 1)'(2 * CAPACITY);
  localparam logic [PTR_W:0] CAP_W   = (PTR_W + 1)'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [$bits(entry_t)-1:0] mem [CAPACITY];
  logic [$bits(entry_t)-1:0] rdata;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [63:0]      drops;
  logic [63:0]      pending;
  entry_t           cur;
  logic             acc;
  logic             mark;
  logic             popv;
  logic             res_valid;

  logic             mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] fill;
  logic             fits;
  logic             done;
  logic [PTR_W-1:0] wp_next;
  logic [PTR_W-1:0] rp_next;
  entry_t           rd_entry;
  entry_t           marker;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] pw;
    pw = {1'b0, p};
    if (pw == PTR_MOD - 1'b1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] pw;
    pw = {1'b0, p};
    if (pw >= CAP_W) begin
      pw = pw - CAP_W;
    end
    return pw[SLOT_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] w,
                                               input logic [PTR_W-1:0] r);
    logic [PTR_W:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + PTR_MOD;
    end
    return d[PTR_W-1:0];
  endfunction

  assign fill     = fill_of(wp, rp);
  assign fits     = ({1'b0, fill} + ((pending != '0) ? (PTR_W + 1)'(2) : (PTR_W + 1)'(1)))
                    <= CAP_W;
  assign done     = (state == S_EXEC) && (!res_valid || pop);
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign empty    = !res_valid;
  assign rd_entry = entry_t'(rdata);
  assign wp_next  = acc ? ptr_inc(wp) : wp;
  assign rp_next  = popv ? ptr_inc(rp) : rp;

  always_comb begin
    marker         = cmd.ev;
    marker.ev_type = cfg.loss_kind_code;
    marker.span    = pending;
  end

  // Share the single write port: marker on the take cycle, event on completion.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_of(wp);
    mem_wdata = cur;
    mem_re    = 1'b0;
    if (cmd_take) begin
      if (cmd.op == OP_APPEND) begin
        if (cfg.enable && fits && (pending != '0)) begin
          mem_we    = 1'b1;
          mem_wdata = marker;
        end
      end else if (fill != '0) begin
        mem_re = 1'b1;
      end
    end else if (done && acc) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[slot_of(rp)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      rp        <= '0;
      drops     <= '0;
      pending   <= '0;
      acc       <= 1'b0;
      mark      <= 1'b0;
      popv      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && pop && !done) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd.ev;
            acc   <= (cmd.op == OP_APPEND) && cfg.enable && fits;
            mark  <= (cmd.op == OP_APPEND) && cfg.enable && fits && (pending != '0);
            popv  <= (cmd.op == OP_POP) && (fill != '0);
            state <= S_EXEC;
            if ((cmd.op == OP_APPEND) && cfg.enable) begin
              if (fits) begin
                if (pending != '0) begin
                  wp      <= ptr_inc(wp);
                  pending <= '0;
                end
              end else begin
                drops   <= drops + 64'd1;
                pending <= pending + 64'd1;
              end
            end
          end
        end
        S_EXEC: begin
          // Hold until the result slot frees up.
          if (done) begin
            wp                     <= wp_next;
            rp                     <= rp_next;
            res_valid              <= 1'b1;
            result.out_valid       <= popv;
            result.accepted        <= acc;
            result.marker_inserted <= mark;
            result.out_type        <= popv ? rd_entry.ev_type : '0;
            result.out_time_stamp  <= popv ? rd_entry.stamp : '0;
            result.out_span        <= popv ? rd_entry.span : '0;
            result.out_extra       <= popv ? rd_entry.extra : '0;
            result.fill_level      <= FILL_W'(fill_of(wp_next, rp_next));
            result.dropped_total   <= drops;
            result.pending_drops   <= pending;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/trace_ring_with_loss_marker.sv =====
`timescale 1ns / 1ps
// Trace event FIFO that drops appends when short of room and later stores a
// loss marker (kind = loss_kind_code, span = drops owed) ahead of the next
// append that fits.
// Input queue: push/full. Each word is an append (kind 0) or a pop of the
// oldest entry (kind 1). Every word yields exactly one result word.
// Result queue: empty/pop. The oldest result sits on result while empty is low.
// Config: cfg_valid/cfg_ready, always ready; index 0 enable, 1 loss kind code.
// Write config only while the block is idle.
// A taken word is dispatched to the sequencer, then executed in S_EXEC, which
// registers its result and holds while the result slot is still full.
// The execute sequencer takes no new word until it is done with the last: an
// append may store a marker and the event through the one write port of the
// 1024-entry store, and a pop waits on its registered read.
// Reset clears pointers, drop counters, both queues and the config (enable 1,
// loss kind 0). Store contents are not cleared and need no clearing pass.
// When the receiver stalls, the result is held, the next word is dispatched and
// waits in execute, the two-word input queue fills and full rises.
module trace_ring_with_loss_marker
  import trf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  item_t                item,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b1;
      cfg.loss_kind_code <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:    cfg.enable         <= cfg_data[0];
        REG_LOSS_KIND: cfg.loss_kind_code <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  trf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  trf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== tb/sv/trace_ring_checker.sv =====
`timescale 1ns / 1ps
module trace_ring_checker
  import trf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  item_t                item,
  input  logic                 empty,
  input  logic                 pop,
  input  result_t              result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   checked,
  output int                   markers,
  output logic [63:0]          drop_total
);

  entry_t            trace_copy [CAPACITY];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [63:0]       drops;
  logic [63:0]       owed;
  logic              en;
  logic [15:0]       loss_kind;
  result_t           expected_results [$];

  // Advance the local copy of the ring by one word and return its result word.
  function automatic result_t ring_result(item_t w);
    result_t           r;
    entry_t            ent;
    logic [FILL_W-1:0] fill;
    int unsigned       need;
    r    = '0;
    fill = FILL_W'(wr_ptr - rd_ptr);
    if (op_t'(w.kind) == OP_APPEND) begin
      if (en) begin
        need = (owed != 0) ? 2 : 1;
        if (int'(fill) + need > CAPACITY) begin
          drops = drops + 64'd1;
          owed  = owed + 64'd1;
        end else begin
          if (owed != 0) begin
            trace_copy[wr_ptr[SLOT_W-1:0]] = '{ev_type: loss_kind, stamp: w.time_stamp,
                                               span: owed, extra: w.extra_word};
            wr_ptr = wr_ptr + 1'b1;
            owed   = '0;
            r.marker_inserted = 1'b1;
          end
          trace_copy[wr_ptr[SLOT_W-1:0]] = '{ev_type: w.event_type, stamp: w.time_stamp,
                                             span: w.span, extra: w.extra_word};
          wr_ptr = wr_ptr + 1'b1;
          r.accepted = 1'b1;
        end
      end
    end else if (fill != 0) begin
      ent              = trace_copy[rd_ptr[SLOT_W-1:0]];
      rd_ptr           = rd_ptr + 1'b1;
      r.out_valid      = 1'b1;
      r.out_type       = ent.ev_type;
      r.out_time_stamp = ent.stamp;
      r.out_span       = ent.span;
      r.out_extra      = ent.extra;
    end
    r.fill_level    = FILL_W'(wr_ptr - rd_ptr);
    r.dropped_total = drops;
    r.pending_drops = owed;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      drops      = '0;
      owed       = '0;
      en         = 1'b1;
      loss_kind  = '0;
      mismatches = 0;
      checked    = 0;
      markers    = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:    en = cfg_data[0];
          REG_LOSS_KIND: loss_kind = cfg_data[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          checked++;
          check_field("out_valid", 64'(exp_r.out_valid), 64'(result.out_valid));
          check_field("accepted", 64'(exp_r.accepted), 64'(result.accepted));
          check_field("marker_inserted", 64'(exp_r.marker_inserted),
                      64'(result.marker_inserted));
          check_field("out_type", 64'(exp_r.out_type), 64'(result.out_type));
          check_field("out_time_stamp", exp_r.out_time_stamp, result.out_time_stamp);
          check_field("out_span", exp_r.out_span, result.out_span);
          check_field("out_extra", exp_r.out_extra, result.out_extra);
          check_field("fill_level", 64'(exp_r.fill_level), 64'(result.fill_level));
          check_field("dropped_total", exp_r.dropped_total, result.dropped_total);
          check_field("pending_drops", exp_r.pending_drops, result.pending_drops);
        end
      end
      if (push && !full) begin
        exp_r = ring_result(item);
        if (exp_r.marker_inserted) markers++;
        expected_results.insert(expected_results.size(), exp_r);
      end
    end
    outstanding = expected_results.size();
    drop_total  = drops;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import trf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  item_t                item      = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ENABLE;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int          mismatches;
  int          outstanding;
  int          checked;
  int          markers;
  logic [63:0] drop_total;

  logic        quiet      = 1'b0;
  int          stall_left = 0;
  int          words_sent = 0;
  int unsigned cycles     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trace_ring_with_loss_marker dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trace_ring_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .markers     (markers),
    .drop_total  (drop_total)
  );

  // Result side: take a word most cycles, stall in short bursts while not quiet.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (!quiet && stall_left > 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic item_t random_word(op_t op);
    item_t w;
    w.kind       = op;
    w.event_type = 16'($urandom);
    w.time_stamp = {$urandom, $urandom};
    w.span       = {$urandom, $urandom};
    w.extra_word = {$urandom, $urandom};
    return w;
  endfunction

  task automatic send_word(input item_t w);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop push and hold until every expected result word has been taken.
  task automatic wait_drained;
    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mixed appends and pops; the pop share shifts every 50 words so the
  // fill level rises and falls.
  task automatic run_mix(input int count);
    int pop_pct;
    pop_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) pop_pct = 30 + 20 * $urandom_range(0, 2);
      send_word(random_word(($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_APPEND));
    end
  endtask

  initial begin
    item_t w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_LOSS_KIND, 16'hFFFF);
    write_reg(REG_ENABLE, CFG_DAT_W'(1));

    // Directed: empty pop, all-zero and all-one appends, read back, empty again.
    send_word(random_word(OP_POP));
    w = '0;
    send_word(w);
    w = '1;
    w.kind = OP_APPEND;
    send_word(w);
    send_word(random_word(OP_APPEND));
    send_word(random_word(OP_POP));
    send_word(random_word(OP_POP));
    send_word(random_word(OP_POP));
    send_word(random_word(OP_POP));
    wait_drained();

    // Appends while disabled are ignored; pops still run.
    write_reg(REG_ENABLE, CFG_DAT_W'(0));
    send_word(w);
    send_word(random_word(OP_APPEND));
    send_word(random_word(OP_POP));
    wait_drained();
    write_reg(REG_ENABLE, CFG_DAT_W'(1));

    run_mix(300);
    wait_drained();

    write_reg(REG_LOSS_KIND, CFG_DAT_W'($urandom));
    run_mix(300);
    wait_drained();

    write_reg(REG_ENABLE, CFG_DAT_W'(0));
    run_mix(40);
    wait_drained();
    write_reg(REG_ENABLE, CFG_DAT_W'(1));
    write_reg(REG_LOSS_KIND, 16'h0000);

    quiet = 1'b1;
    run_mix(200);
    for (int i = 0; i < 50; i++) send_word(random_word(OP_POP));
    wait_drained();
    repeat (8) @(negedge clk);

    $display("sent %0d words, checked %0d result words, %0d with a loss marker",
             words_sent, checked, markers);
    $display("appends dropped: %0d; loss kinds all-ones, random, zero; enable on and off",
             drop_total);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
